// ===== sv/nrsh_pkg.sv =====
// Shared types and constants for the nearest ray segment hit block.
`timescale 1ns / 1ps

package nrsh_pkg;

  // Field widths of the input and result beats.
  localparam int COORD_W = 32;
  localparam int OP_W    = 2;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 8;

  // Width of the cross products and their differences.
  localparam int PROD_W = 64;
  localparam int WIDE_W = 66;

  // Number of multiplier bits that the scaling divider walks through.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Scale that turns the ray fraction into Q0.16.
  localparam logic [COORD_W-1:0] FRAC_SCALE = 32'h0001_0000;
  localparam logic [FRAC_W-1:0]  MISS_FRAC  = 16'hFFFF;

  // Opcodes of the input beat.
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_CAST   = 2'd2;

  // Status of the scaling divider as seen by the sequencer.
  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quot;
    logic               rem_nz;
  } nrsh_div_res_t;

endpackage

// ===== sv/nrsh_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module nrsh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, loaded while re is high.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/nrsh_scale_div.sv =====
// Bit-serial unit that computes floor(mult * num / den) for num < den.
`timescale 1ns / 1ps

module nrsh_scale_div import nrsh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [COORD_W-1:0]  mult,
  input  logic [PROD_W-1:0]   num,
  input  logic [PROD_W-1:0]   den,
  output nrsh_div_res_t       res
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WIDE_W-1:0]    rem_r;
  logic [COORD_W-1:0]   quot_r;
  logic [COORD_W-1:0]   mult_r;

  logic [WIDE_W-1:0]    step_sum;
  logic [WIDE_W-1:0]    den_one;
  logic [WIDE_W-1:0]    den_two;
  logic [WIDE_W-1:0]    rem_nxt;
  logic [1:0]           inc;
  logic [COORD_W-1:0]   quot_nxt;

  // One multiplier bit per cycle: double the remainder, add num when the bit
  // is set, then take out den up to twice. The remainder stays below den.
  always_comb begin
    den_one  = WIDE_W'(den);
    den_two  = {den_one[WIDE_W-2:0], 1'b0};
    step_sum = {rem_r[WIDE_W-2:0], 1'b0} + (mult_r[COORD_W-1] ? WIDE_W'(num) : '0);
    if (step_sum >= den_two) begin
      rem_nxt = step_sum - den_two;
      inc     = 2'd2;
    end else if (step_sum >= den_one) begin
      rem_nxt = step_sum - den_one;
      inc     = 2'd1;
    end else begin
      rem_nxt = step_sum;
      inc     = 2'd0;
    end
    quot_nxt = {quot_r[COORD_W-2:0], 1'b0} + COORD_W'(inc);
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
      done_r <= !start && busy_r && (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
    end
  end

  // Remainder, quotient and multiplier shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= '0;
      mult_r <= mult;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
      mult_r <= {mult_r[COORD_W-2:0], 1'b0};
    end
  end

  assign res.done   = done_r;
  assign res.quot   = quot_r;
  assign res.rem_nz = (rem_r != '0);

endmodule

// ===== sv/nearest_ray_segment_hit_top.sv =====
// Top level of the nearest ray segment hit block: segment table and cast sequencer.
`timescale 1ns / 1ps

// The block keeps up to MAX_SEGMENTS wall segments in two RAMs and answers each
// cast with the nearest segment that the ray strikes, or with the ray end on a miss.
// A clear or an append is done on acceptance. A cast walks the table one entry at a
// time through a read, difference, multiply, subtract, sign-fix and test step; a hit
// that must be ranked against an earlier hit then passes through the multiply, sum
// and compare steps of the cross-multiplying compare. When a hit is found, the serial
// scaling divider runs three times (x offset, y offset and ray fraction) at one bit
// per cycle. A cast against an empty table goes straight to the done step. Only one
// beat is worked on at a time; a finished result waits in the output register while
// new beats are taken.
module nearest_ray_segment_hit_top import nrsh_pkg::*; #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OP_W-1:0]           in_opcode,
  input  logic signed [COORD_W-1:0] in_origin_x,
  input  logic signed [COORD_W-1:0] in_origin_y,
  input  logic signed [COORD_W-1:0] in_vector_x,
  input  logic signed [COORD_W-1:0] in_vector_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic [FRAC_W-1:0]         out_ray_fraction,
  output logic [IDX_W-1:0]          out_segment_index
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_MUL,
    S_SUB,
    S_NORM,
    S_TEST,
    S_CMUL,
    S_CSUM,
    S_CCMP,
    S_DIVX,
    S_DIVY,
    S_DIVF,
    S_DONE
  } state_t;

  // Control state.
  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] k_r;
  logic          have_r;
  logic          div_run_r;

  // Ray held for the whole cast.
  logic signed [COORD_W-1:0] px_r, py_r, rx_r, ry_r;

  // Per-segment datapath registers.
  logic signed [COORD_W-1:0] sx_r, sy_r;
  logic signed [COORD_W:0]   dx_r, dy_r;
  logic signed [PROD_W-1:0]  m_sxry_r, m_syrx_r;
  logic signed [PROD_W:0]    m_sxdy_r, m_sydx_r, m_rxdy_r, m_rydx_r;
  logic signed [WIDE_W-1:0]  den_r, n1_r, n2_r;

  // Ranking registers: partial products and full products of the cross compare.
  logic [PROD_W-1:0]   pa_ll_r, pa_lh_r, pa_hl_r, pa_hh_r;
  logic [PROD_W-1:0]   pb_ll_r, pb_lh_r, pb_hl_r, pb_hh_r;
  logic [2*PROD_W-1:0] lhs_r, rhs_r;

  // Best hit so far.
  logic [PROD_W-1:0] best_num_r, best_den_r;
  logic [AW-1:0]     best_k_r;

  // Final hit point and fraction.
  logic [COORD_W-1:0] hit_x_r, hit_y_r;
  logic [FRAC_W-1:0]  frac_r;

  // Output register.
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic signed [COORD_W-1:0] out_point_x_r, out_point_y_r;
  logic [FRAC_W-1:0]         out_frac_r;
  logic [IDX_W-1:0]          out_idx_r;

  logic              accept;
  logic              load_out;
  logic              ram_we;
  logic              ram_re;
  logic [2*COORD_W-1:0] rd_start, rd_vec;
  logic signed [COORD_W-1:0] seg_qx, seg_qy;
  logic              seg_ok;
  logic              last_seg;
  logic              is_div;
  logic              div_start;
  logic [COORD_W-1:0] div_mult;
  logic              div_neg;
  logic [COORD_W-1:0] div_base;
  logic [COORD_W-1:0] q_adj, offset;
  logic [COORD_W-1:0] rx_mag, ry_mag;
  logic [AW+IDX_W-1:0] best_k_ext;
  nrsh_div_res_t     div_res;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // A finished cast enters the output register once it is free or being drained.
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Table stores: start point and direction, y in the upper half.
  assign ram_we = accept && (in_opcode == OP_APPEND) && (count_r < CW'(MAX_SEGMENTS));
  assign ram_re = (state_r == S_READ);

  nrsh_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_SEGMENTS)) u_start_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_origin_y, in_origin_x}),
    .re    (ram_re),
    .raddr (k_r[AW-1:0]),
    .rdata (rd_start)
  );

  nrsh_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_SEGMENTS)) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_vector_y, in_vector_x}),
    .re    (ram_re),
    .raddr (k_r[AW-1:0]),
    .rdata (rd_vec)
  );

  assign seg_qx = rd_start[COORD_W-1:0];
  assign seg_qy = rd_start[2*COORD_W-1:COORD_W];

  // Strike test on the sign-fixed cross products.
  assign seg_ok = (den_r != '0) && !n1_r[WIDE_W-1] && (n1_r < den_r) &&
                  !n2_r[WIDE_W-1] && !(den_r < n2_r);
  assign last_seg = (k_r == count_r - 1'b1);

  // Divider operand selection for the x offset, y offset and fraction runs.
  assign rx_mag    = rx_r[COORD_W-1] ? (~rx_r + 1'b1) : rx_r;
  assign ry_mag    = ry_r[COORD_W-1] ? (~ry_r + 1'b1) : ry_r;
  assign is_div    = (state_r == S_DIVX) || (state_r == S_DIVY) || (state_r == S_DIVF);
  assign div_start = is_div && !div_run_r;

  always_comb begin
    case (state_r)
      S_DIVX:  div_mult = rx_mag;
      S_DIVY:  div_mult = ry_mag;
      default: div_mult = FRAC_SCALE;
    endcase
  end

  nrsh_scale_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mult  (div_mult),
    .num   (best_num_r),
    .den   (best_den_r),
    .res   (div_res)
  );

  // Floor toward minus infinity: a negative product with a remainder rounds down.
  assign div_neg  = (state_r == S_DIVY) ? ry_r[COORD_W-1] : rx_r[COORD_W-1];
  assign div_base = (state_r == S_DIVY) ? py_r : px_r;
  assign q_adj    = div_res.quot + (div_neg ? COORD_W'(div_res.rem_nz) : '0);
  assign offset   = div_neg ? ('0 - q_adj) : q_adj;

  assign best_k_ext = {{IDX_W{1'b0}}, best_k_r};

  // Sequencer: state, table count, scan index and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      have_r      <= 1'b0;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_opcode)
              OP_CLEAR: count_r <= '0;
              OP_APPEND: begin
                if (count_r < CW'(MAX_SEGMENTS)) begin
                  count_r <= count_r + 1'b1;
                end
              end
              OP_CAST: begin
                have_r  <= 1'b0;
                k_r     <= '0;
                state_r <= (count_r == '0) ? S_DONE : S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: state_r <= S_DIFF;
        S_DIFF: state_r <= S_MUL;
        S_MUL:  state_r <= S_SUB;
        S_SUB:  state_r <= S_NORM;
        S_NORM: state_r <= S_TEST;
        S_TEST: begin
          if (seg_ok && have_r) begin
            state_r <= S_CMUL;
          end else begin
            if (seg_ok) begin
              have_r <= 1'b1;
            end
            if (last_seg) begin
              state_r <= (have_r || seg_ok) ? S_DIVX : S_DONE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        S_CMUL: state_r <= S_CSUM;
        S_CSUM: state_r <= S_CCMP;
        S_CCMP: begin
          if (last_seg) begin
            state_r <= S_DIVX;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_DIVX, S_DIVY, S_DIVF: begin
          if (div_start) begin
            div_run_r <= 1'b1;
          end else if (div_res.done) begin
            div_run_r <= 1'b0;
            case (state_r)
              S_DIVX:  state_r <= S_DIVY;
              S_DIVY:  state_r <= S_DIVF;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_hit_r   <= have_r;
            if (have_r) begin
              out_point_x_r <= hit_x_r;
              out_point_y_r <= hit_y_r;
              out_frac_r    <= frac_r;
              out_idx_r     <= best_k_ext[IDX_W-1:0];
            end else begin
              out_point_x_r <= px_r + rx_r;
              out_point_y_r <= py_r + ry_r;
              out_frac_r    <= MISS_FRAC;
              out_idx_r     <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, loaded as the sequencer passes through each step.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          px_r <= in_origin_x;
          py_r <= in_origin_y;
          rx_r <= in_vector_x;
          ry_r <= in_vector_y;
        end
      end
      S_DIFF: begin
        dx_r <= (COORD_W+1)'(seg_qx) - (COORD_W+1)'(px_r);
        dy_r <= (COORD_W+1)'(seg_qy) - (COORD_W+1)'(py_r);
        sx_r <= rd_vec[COORD_W-1:0];
        sy_r <= rd_vec[2*COORD_W-1:COORD_W];
      end
      S_MUL: begin
        m_sxry_r <= PROD_W'(sx_r) * PROD_W'(ry_r);
        m_syrx_r <= PROD_W'(sy_r) * PROD_W'(rx_r);
        m_sxdy_r <= (PROD_W+1)'(sx_r) * (PROD_W+1)'(dy_r);
        m_sydx_r <= (PROD_W+1)'(sy_r) * (PROD_W+1)'(dx_r);
        m_rxdy_r <= (PROD_W+1)'(rx_r) * (PROD_W+1)'(dy_r);
        m_rydx_r <= (PROD_W+1)'(ry_r) * (PROD_W+1)'(dx_r);
      end
      S_SUB: begin
        den_r <= WIDE_W'(m_sxry_r) - WIDE_W'(m_syrx_r);
        n1_r  <= WIDE_W'(m_sxdy_r) - WIDE_W'(m_sydx_r);
        n2_r  <= WIDE_W'(m_rxdy_r) - WIDE_W'(m_rydx_r);
      end
      S_NORM: begin
        // Make the denominator positive so the range tests are plain compares.
        if (den_r[WIDE_W-1]) begin
          den_r <= -den_r;
          n1_r  <= -n1_r;
          n2_r  <= -n2_r;
        end
      end
      S_TEST: begin
        if (seg_ok && !have_r) begin
          best_num_r <= n1_r[PROD_W-1:0];
          best_den_r <= den_r[PROD_W-1:0];
          best_k_r   <= k_r[AW-1:0];
        end
      end
      S_CMUL: begin
        // Candidate n1 * best_den against best_num * den, in 32-bit halves.
        pa_ll_r <= PROD_W'(n1_r[31:0])  * PROD_W'(best_den_r[31:0]);
        pa_lh_r <= PROD_W'(n1_r[31:0])  * PROD_W'(best_den_r[63:32]);
        pa_hl_r <= PROD_W'(n1_r[63:32]) * PROD_W'(best_den_r[31:0]);
        pa_hh_r <= PROD_W'(n1_r[63:32]) * PROD_W'(best_den_r[63:32]);
        pb_ll_r <= PROD_W'(best_num_r[31:0])  * PROD_W'(den_r[31:0]);
        pb_lh_r <= PROD_W'(best_num_r[31:0])  * PROD_W'(den_r[63:32]);
        pb_hl_r <= PROD_W'(best_num_r[63:32]) * PROD_W'(den_r[31:0]);
        pb_hh_r <= PROD_W'(best_num_r[63:32]) * PROD_W'(den_r[63:32]);
      end
      S_CSUM: begin
        lhs_r <= (2*PROD_W)'(pa_ll_r) + ((2*PROD_W)'(pa_lh_r) << 32) +
                 ((2*PROD_W)'(pa_hl_r) << 32) + ((2*PROD_W)'(pa_hh_r) << 64);
        rhs_r <= (2*PROD_W)'(pb_ll_r) + ((2*PROD_W)'(pb_lh_r) << 32) +
                 ((2*PROD_W)'(pb_hl_r) << 32) + ((2*PROD_W)'(pb_hh_r) << 64);
      end
      S_CCMP: begin
        // Strictly nearer only, so the earlier entry keeps a tie.
        if (lhs_r < rhs_r) begin
          best_num_r <= n1_r[PROD_W-1:0];
          best_den_r <= den_r[PROD_W-1:0];
          best_k_r   <= k_r[AW-1:0];
        end
      end
      S_DIVX: begin
        if (div_res.done) begin
          hit_x_r <= div_base + offset;
        end
      end
      S_DIVY: begin
        if (div_res.done) begin
          hit_y_r <= div_base + offset;
        end
      end
      S_DIVF: begin
        if (div_res.done) begin
          frac_r <= div_res.quot[FRAC_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_point_x       = out_point_x_r;
  assign out_point_y       = out_point_y_r;
  assign out_ray_fraction  = out_frac_r;
  assign out_segment_index = out_idx_r;

`ifndef SYNTHESIS
  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  // A kept hit always lies strictly before the ray end.
  a_best_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    have_r && (state_r == S_DIVX || state_r == S_DIVY || state_r == S_DIVF) |->
    best_num_r < best_den_r)
    else $error("best hit fraction not below one");

  // The divider reports only while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIVX || state_r == S_DIVY || state_r == S_DIVF))
    else $error("divider finished outside a divide step");

  // A new cast result is loaded only after the previous beat has left.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && state_r == S_DONE |=> state_r == S_DONE)
    else $error("result loaded over a waiting beat");
`endif

endmodule
